// ===== rtl/core/srwl_pkg.sv =====
// ============================================================================
// srwl_pkg
// Shared types for the sample ring with cached lower and upper limits.
// ============================================================================
`default_nettype none

package srwl_pkg;

    // operation carried by each input word
    typedef enum logic [1:0] {
        MODE_PUSH   = 2'd0,
        MODE_READ   = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_LIMITS = 2'd3
    } t_mode;

    // one result word
    typedef struct packed {
        logic signed [31:0] read_value;
        logic signed [31:0] lower_limit;
        logic signed [31:0] upper_limit;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/sample_ring_with_limits.sv =====
// ============================================================================
// sample_ring_with_limits
// Circular store of DEPTH signed Q16.16 samples with a cached min/max.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one operation per word:
//   push a sample, read by age (0 = oldest), clear, or query limits.
//   Output channel (o_out_valid / i_out_stall) returns exactly one word per
//   input word, in order. Unused result fields are zero.
//   Steps per word:
//     push          writes the sample at the head; no memory read
//     read          one registered read at head + age when DEPTH is a power
//                   of two; else the age is first wrapped by a reciprocal
//                   multiply, then one compare and subtract on head + age
//     limits        returns the cache when it is valid; rescans the store when
//                   a push has made it stale (one memory read per cycle)
//     clear         zeroes every entry (one entry zeroed per cycle)
//   Reset: a zeroing pass over every entry runs first; o_in_stall stays high
//   until it ends. Head, cached limits and the stale flag reset to zero.
//   Stall: a finished result waits in a holding register while the output
//   register is stalled; the next word is not taken until it moves on.
// ============================================================================
`default_nettype none

module sample_ring_with_limits #(
    parameter int DEPTH = 1024
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // input channel
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire  [1:0]          i_mode,
    input  wire  signed [31:0]  i_sample_value,
    input  wire  [9:0]          i_age_index,
    // output channel
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output logic signed [31:0]  o_read_value,
    output logic signed [31:0]  o_lower_limit,
    output logic signed [31:0]  o_upper_limit
);
    import srwl_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW = ((AW > 10) ? AW : 10) + 1;
    localparam int RS = 20;
    localparam int PW = RS + 10;
    localparam int QW = AW + 11;
    localparam bit IS_POW2 = ((DEPTH & (DEPTH - 1)) == 0);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [SW-1:0] DEPTH_W = SW'(DEPTH);
    // ceil(2^RS / DEPTH), exact quotient for any 10-bit age
    localparam logic [RS-1:0] RECIP = RS'(((2 ** RS) + DEPTH - 1) / DEPTH);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SWEEP  = 7'b0000010,
        ST_REDUCE = 7'b0000100,
        ST_RDATA  = 7'b0001000,
        ST_SCAN   = 7'b0010000,
        ST_TAIL   = 7'b0100000,
        ST_WAIT   = 7'b1000000
    } t_state;

    // sample memory
    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] r_rd_data;
    logic               wr_en, rd_en;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic signed [31:0] wr_data;

    // control state
    t_state             r_state, n_state;
    logic [AW-1:0]      r_head, n_head;
    logic [AW-1:0]      r_cnt, n_cnt;
    logic signed [31:0] r_cmin, n_cmin, r_cmax, n_cmax;
    logic               r_stale, n_stale;
    logic               r_clr, n_clr;
    logic               r_first, n_first;
    logic               r_scan_vld;
    logic               r_out_valid, n_out_valid;

    // payload
    t_result            r_out, n_out, r_hold, n_hold;
    logic [SW-1:0]      r_rem, n_rem;
    logic               r_step, n_step;
    logic [9:0]         r_quo, n_quo;
    logic [9:0]         r_age, n_age;
    logic signed [31:0] r_lo, n_lo, r_hi, n_hi;

    logic               in_acc, out_free, fin;
    t_result            fin_res;
    logic [SW-1:0]      sum;
    logic [SW-1:0]      red_rem;
    logic [PW-1:0]      prod;
    logic [9:0]         quo_est;
    logic [QW-1:0]      qd;
    logic [9:0]         age_mod;
    logic signed [31:0] mrg_lo, mrg_hi;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_read_value  = r_out.read_value;
    assign o_lower_limit = r_out.lower_limit;
    assign o_upper_limit = r_out.upper_limit;

    // entry address before wrap
    assign sum = SW'(r_head) + SW'(i_age_index);

    // age / DEPTH by reciprocal multiply, then age mod DEPTH
    assign prod    = PW'(i_age_index) * PW'(RECIP);
    assign quo_est = prod[PW-1:RS];
    assign qd      = QW'(r_quo) * QW'(DEPTH);
    assign age_mod = r_age - qd[9:0];

    // head + wrapped age is below 2*DEPTH, one compare and subtract
    always_comb begin
        if (r_rem >= DEPTH_W) begin
            red_rem = r_rem - DEPTH_W;
        end else begin
            red_rem = r_rem;
        end
    end

    // running min/max merge with the word just read
    always_comb begin
        if (r_first) begin
            mrg_lo = r_rd_data;
            mrg_hi = r_rd_data;
        end else begin
            mrg_lo = (r_rd_data < r_lo) ? r_rd_data : r_lo;
            mrg_hi = (r_hi < r_rd_data) ? r_rd_data : r_hi;
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_cnt       = r_cnt;
        n_cmin      = r_cmin;
        n_cmax      = r_cmax;
        n_stale     = r_stale;
        n_clr       = r_clr;
        n_first     = r_first;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        n_hold      = r_hold;
        n_rem       = r_rem;
        n_step      = r_step;
        n_quo       = r_quo;
        n_age       = r_age;
        n_lo        = r_lo;
        n_hi        = r_hi;
        wr_en       = 1'b0;
        wr_addr     = r_head;
        wr_data     = i_sample_value;
        rd_en       = 1'b0;
        rd_addr     = r_cnt;
        fin         = 1'b0;
        fin_res     = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (t_mode'(i_mode))
                        MODE_PUSH: begin
                            wr_en   = 1'b1;
                            n_head  = (r_head == LAST) ? '0 : r_head + 1'b1;
                            n_stale = 1'b1;
                            fin     = 1'b1;
                        end
                        MODE_READ: begin
                            if (IS_POW2) begin
                                rd_en   = 1'b1;
                                rd_addr = sum[AW-1:0];
                                n_state = ST_RDATA;
                            end else begin
                                n_quo   = quo_est;
                                n_age   = i_age_index;
                                n_step  = 1'b0;
                                n_state = ST_REDUCE;
                            end
                        end
                        MODE_CLEAR: begin
                            n_cmin  = '0;
                            n_cmax  = '0;
                            n_stale = 1'b0;
                            n_cnt   = '0;
                            n_clr   = 1'b1;
                            n_state = ST_SWEEP;
                        end
                        MODE_LIMITS: begin
                            if (r_stale) begin
                                n_cnt   = '0;
                                n_first = 1'b1;
                                n_state = ST_SCAN;
                            end else begin
                                fin                 = 1'b1;
                                fin_res.lower_limit = r_cmin;
                                fin_res.upper_limit = r_cmax;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // zero one entry per cycle
            ST_SWEEP: begin
                wr_en   = 1'b1;
                wr_addr = r_cnt;
                wr_data = '0;
                if (r_cnt == LAST) begin
                    if (r_clr) begin
                        fin = 1'b1;
                    end else begin
                        n_state = ST_IDLE;
                    end
                    n_clr = 1'b0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            // wrap the age address: add the head, then fold once
            ST_REDUCE: begin
                if (!r_step) begin
                    n_rem  = SW'(r_head) + SW'(age_mod);
                    n_step = 1'b1;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = red_rem[AW-1:0];
                    n_state = ST_RDATA;
                end
            end
            ST_RDATA: begin
                fin                = 1'b1;
                fin_res.read_value = r_rd_data;
            end
            // walk the store, read data is registered and arrives the cycle after its address
            ST_SCAN: begin
                rd_en   = 1'b1;
                rd_addr = r_cnt;
                if (r_scan_vld) begin
                    n_lo    = mrg_lo;
                    n_hi    = mrg_hi;
                    n_first = 1'b0;
                end
                if (r_cnt == LAST) begin
                    n_state = ST_TAIL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_TAIL: begin
                n_cmin              = mrg_lo;
                n_cmax              = mrg_hi;
                n_stale             = 1'b0;
                fin                 = 1'b1;
                fin_res.lower_limit = mrg_lo;
                fin_res.upper_limit = mrg_hi;
            end
            ST_WAIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_hold;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // hand the finished word to the output register or hold it
        if (fin) begin
            if (out_free) begin
                n_out_valid = 1'b1;
                n_out       = fin_res;
                n_state     = ST_IDLE;
            end else begin
                n_hold  = fin_res;
                n_state = ST_WAIT;
            end
        end
    end

    // memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SWEEP;
            r_head      <= '0;
            r_cnt       <= '0;
            r_cmin      <= '0;
            r_cmax      <= '0;
            r_stale     <= 1'b0;
            r_clr       <= 1'b0;
            r_first     <= 1'b0;
            r_scan_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_cnt       <= n_cnt;
            r_cmin      <= n_cmin;
            r_cmax      <= n_cmax;
            r_stale     <= n_stale;
            r_clr       <= n_clr;
            r_first     <= n_first;
            r_scan_vld  <= (r_state == ST_SCAN);
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_hold <= n_hold;
        r_rem  <= n_rem;
        r_step <= n_step;
        r_quo  <= n_quo;
        r_age  <= n_age;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
    end

    // checks
    a_push_stale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_mode == MODE_PUSH) |=> r_stale)
        else $error("push did not mark the limit cache stale");

    a_clear_cache: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_mode == MODE_CLEAR) |=> (r_cmin == '0) && (r_cmax == '0) && !r_stale)
        else $error("clear did not reset the limit cache");

    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TAIL) |=> !r_stale && !(r_cmax < r_cmin))
        else $error("rescan left an inconsistent limit cache");

    a_wait_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WAIT) |-> r_out_valid)
        else $error("holding a word while the output register is empty");

endmodule

`default_nettype wire
